// File: rtl/rgp_pkg.sv
// Shared types and constants for the radial gradient pixel pipeline.
// No dependencies.
package rgp_pkg;

   // Register indexes on the configuration port.
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_DENSITY      = 3'd2;
   localparam logic [2:0] CSR_INNER_COLOR  = 3'd3;
   localparam logic [2:0] CSR_OUTER_COLOR  = 3'd4;

   // Datapath widths.
   localparam int SQ_W    = 28;  // dx*dx + dy*dy
   localparam int ROOT_W  = 22;  // distance, 8 fraction bits
   localparam int REM_W   = 24;  // square root remainder
   localparam int DIV_W   = 30;  // divider remainder and divisor
   localparam int FRAC_W  = 16;  // quotient bits of the blend factor

   // How the blend factor is formed.
   typedef enum logic [1:0] {
      FC_ZERO,
      FC_FULL,
      FC_DIV
   } factor_class_type;

endpackage

// File: rtl/rgp_sqrt_cell.sv
// One root bit of the integer square root of (sq << 16).
// Depends on rgp_pkg.
module rgp_sqrt_cell #(
   parameter int IDX = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [rgp_pkg::SQ_W-1:0]   in_sq,
   input  logic [rgp_pkg::REM_W-1:0]  in_rem,
   input  logic [rgp_pkg::ROOT_W-1:0] in_root,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [rgp_pkg::SQ_W-1:0]   out_sq,
   output logic [rgp_pkg::REM_W-1:0]  out_rem,
   output logic [rgp_pkg::ROOT_W-1:0] out_root
);

   logic                       valid_ff;
   logic [rgp_pkg::SQ_W-1:0]   sq_ff;
   logic [rgp_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [rgp_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [1:0]                 pair;
   logic [rgp_pkg::REM_W-1:0]  rem_sh, trial;

   // Two radicand bits for this step; the low 16 radicand bits are zero.
   generate
      if (IDX >= 8) begin : g_pair
         assign pair = in_sq[2*IDX-16 +: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end
   endgenerate

   // Compare-and-subtract step.
   always_comb begin
      rem_sh = {in_rem[rgp_pkg::REM_W-3:0], pair};
      trial  = {in_root, 2'b01};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {in_root[rgp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {in_root[rgp_pkg::ROOT_W-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         sq_ff   <= in_sq;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sq    = sq_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;

endmodule

// File: rtl/rgp_div_cell.sv
// One quotient bit of the blend factor division num * 2^16 / den.
// Depends on rgp_pkg.
module rgp_div_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [rgp_pkg::DIV_W-1:0]         den,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  rgp_pkg::factor_class_type         in_cls,
   input  logic [rgp_pkg::DIV_W-1:0]         in_rem,
   input  logic [rgp_pkg::FRAC_W-1:0]        in_quo,
   output logic                              out_valid,
   input  logic                              out_ready,
   output rgp_pkg::factor_class_type         out_cls,
   output logic [rgp_pkg::DIV_W-1:0]         out_rem,
   output logic [rgp_pkg::FRAC_W-1:0]        out_quo
);

   logic                              valid_ff;
   rgp_pkg::factor_class_type         cls_ff;
   logic [rgp_pkg::DIV_W-1:0]         rem_ff, rem_in, rem_sh;
   logic [rgp_pkg::FRAC_W-1:0]        quo_ff, quo_in;

   // Restoring division step; remainder stays below den.
   always_comb begin
      rem_sh = {in_rem[rgp_pkg::DIV_W-2:0], 1'b0};
      if (rem_sh >= den) begin
         rem_in = rem_sh - den;
         quo_in = {in_quo[rgp_pkg::FRAC_W-2:0], 1'b1};
      end else begin
         rem_in = rem_sh;
         quo_in = {in_quo[rgp_pkg::FRAC_W-2:0], 1'b0};
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         cls_ff <= in_cls;
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_cls   = cls_ff;
   assign out_rem   = rem_ff;
   assign out_quo   = quo_ff;

endmodule

// File: rtl/radial_gradient_pixel.sv
// Radial gradient pixel generator: distance, blend factor and RGBA blend.
// Throughput is one request per cycle while results are not stalled.
// The chain is 1 offset stage, 22 square root cells, 1 factor setup stage,
// 16 divider cells and 1 blend/output stage; a stalled result holds the chain
// only as far back as there are no empty stages. Synchronous reset empties the
// chain and loads the register defaults. Depends on rgp_pkg and the cells.
module radial_gradient_pixel #(
   parameter int MAX_DIM = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [11:0] req_pixel_x,
   input  logic [11:0] req_pixel_y,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_alpha,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int NSQ  = rgp_pkg::ROOT_W;
   localparam int NDIV = rgp_pkg::FRAC_W;

   // Configuration registers
   logic [12:0] width_ff, height_ff;
   logic [15:0] density_ff;
   logic [31:0] inner_ff;
   logic [23:0] outer_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= 13'd256;
         height_ff  <= 13'd256;
         density_ff <= 16'd32768;
         inner_ff   <= 32'hFFFF_FFFF;
         outer_ff   <= 24'd0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            rgp_pkg::CSR_IMAGE_WIDTH:  width_ff   <= csr_data[12:0];
            rgp_pkg::CSR_IMAGE_HEIGHT: height_ff  <= csr_data[12:0];
            rgp_pkg::CSR_DENSITY:      density_ff <= csr_data[15:0];
            rgp_pkg::CSR_INNER_COLOR:  inner_ff   <= csr_data;
            rgp_pkg::CSR_OUTER_COLOR:  outer_ff   <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // Values derived from configuration (the user must keep them static while requests are in flight; not enforced here)
   logic [12:0] w_sat, h_sat, m_dim;
   logic [28:0] m_dens;
   logic [rgp_pkg::DIV_W-1:0] den;

   always_comb begin
      w_sat  = ({19'd0, width_ff}  > MAX_DIM) ? 13'(MAX_DIM) : width_ff;
      h_sat  = ({19'd0, height_ff} > MAX_DIM) ? 13'(MAX_DIM) : height_ff;
      m_dim  = (w_sat < h_sat) ? w_sat : h_sat;
      m_dens = {16'd0, m_dim} * {13'd0, density_ff};
      den    = {13'd0, m_dim} * (30'd65536 - {14'd0, density_ff});
   end

   // Offset stage: squared distance in half-pixel units
   logic                     s0_valid_ff;
   logic [rgp_pkg::SQ_W-1:0] s0_sq_ff, s0_sq_in;
   logic signed [14:0]       dx, dy;
   logic signed [29:0]       dx_sq, dy_sq;
   logic                     s0_ready;

   always_comb begin
      dx = $signed({2'b0, req_pixel_x, 1'b0}) - $signed({2'b0, w_sat});
      dy = $signed({2'b0, req_pixel_y, 1'b0}) - $signed({2'b0, h_sat});
      dx_sq = $signed(30'(dx)) * $signed(30'(dx));
      dy_sq = $signed(30'(dy)) * $signed(30'(dy));
      s0_sq_in = rgp_pkg::SQ_W'($unsigned(dx_sq)) + rgp_pkg::SQ_W'($unsigned(dy_sq));
   end

   logic sq_vld [NSQ+1];
   logic sq_rdy [NSQ+1];
   logic [rgp_pkg::SQ_W-1:0]   sq_sq   [NSQ+1];
   logic [rgp_pkg::REM_W-1:0]  sq_rem  [NSQ+1];
   logic [rgp_pkg::ROOT_W-1:0] sq_root [NSQ+1];

   assign s0_ready  = !s0_valid_ff || sq_rdy[0];
   assign req_stall = !s0_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_sq_ff <= s0_sq_in;
      end
   end

   // Square root chain, most significant root bit first
   assign sq_vld[0]  = s0_valid_ff;
   assign sq_sq[0]   = s0_sq_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      rgp_sqrt_cell #(.IDX(NSQ - 1 - k)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (sq_vld[k]),
         .in_ready  (sq_rdy[k]),
         .in_sq     (sq_sq[k]),
         .in_rem    (sq_rem[k]),
         .in_root   (sq_root[k]),
         .out_valid (sq_vld[k+1]),
         .out_ready (sq_rdy[k+1]),
         .out_sq    (sq_sq[k+1]),
         .out_rem   (sq_rem[k+1]),
         .out_root  (sq_root[k+1])
      );
   end

   // Factor setup: classify num against zero and den
   logic                      s1_valid_ff;
   rgp_pkg::factor_class_type s1_cls_ff, s1_cls_in;
   logic [rgp_pkg::DIV_W-1:0] s1_rem_ff;
   logic signed [31:0]        num;
   logic                      s1_ready;

   logic dv_vld [NDIV+1];
   logic dv_rdy [NDIV+1];
   rgp_pkg::factor_class_type   dv_cls [NDIV+1];
   logic [rgp_pkg::DIV_W-1:0]   dv_rem [NDIV+1];
   logic [rgp_pkg::FRAC_W-1:0]  dv_quo [NDIV+1];

   always_comb begin
      num = $signed({2'b0, sq_root[NSQ], 8'd0}) - $signed({3'b0, m_dens});
      priority if (num <= 0) begin
         s1_cls_in = rgp_pkg::FC_ZERO;
      end else if ($unsigned(num) >= {2'b0, den}) begin
         s1_cls_in = rgp_pkg::FC_FULL;
      end else begin
         s1_cls_in = rgp_pkg::FC_DIV;
      end
   end

   assign s1_ready       = !s1_valid_ff || dv_rdy[0];
   assign sq_rdy[NSQ]    = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= sq_vld[NSQ];
      end
   end

   // Remainder only matters when num < den, which fits DIV_W bits
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_cls_ff <= s1_cls_in;
         s1_rem_ff <= num[rgp_pkg::DIV_W-1:0];
      end
   end

   // Divider chain
   assign dv_vld[0] = s1_valid_ff;
   assign dv_cls[0] = s1_cls_ff;
   assign dv_rem[0] = s1_rem_ff;
   assign dv_quo[0] = '0;

   for (genvar k = 0; k < NDIV; k++) begin : g_div
      rgp_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .den       (den),
         .in_valid  (dv_vld[k]),
         .in_ready  (dv_rdy[k]),
         .in_cls    (dv_cls[k]),
         .in_rem    (dv_rem[k]),
         .in_quo    (dv_quo[k]),
         .out_valid (dv_vld[k+1]),
         .out_ready (dv_rdy[k+1]),
         .out_cls   (dv_cls[k+1]),
         .out_rem   (dv_rem[k+1]),
         .out_quo   (dv_quo[k+1])
      );
   end

   // Blend and output register
   logic        out_valid_ff;
   logic [7:0]  red_ff, green_ff, blue_ff, alpha_ff;
   logic [7:0]  red_in, green_in, blue_in, alpha_in;
   logic [16:0] fac, inv;
   logic [25:0] r_sum, g_sum, b_sum, a_prod;
   logic        out_ready;

   always_comb begin
      unique case (dv_cls[NDIV])
         rgp_pkg::FC_ZERO: fac = 17'd0;
         rgp_pkg::FC_FULL: fac = 17'd65536;
         default:          fac = {1'b0, dv_quo[NDIV]};
      endcase
      inv    = 17'd65536 - fac;
      a_prod = {1'b0, 8'd0, inv} * {18'd0, inner_ff[7:0]};
      r_sum  = ({9'd0, fac} * {18'd0, outer_ff[23:16]})
             + ({9'd0, inv} * {18'd0, inner_ff[31:24]});
      g_sum  = ({9'd0, fac} * {18'd0, outer_ff[15:8]})
             + ({9'd0, inv} * {18'd0, inner_ff[23:16]});
      b_sum  = ({9'd0, fac} * {18'd0, outer_ff[7:0]})
             + ({9'd0, inv} * {18'd0, inner_ff[15:8]});
      alpha_in = a_prod[23:16];
      if (alpha_in == 8'd0) begin
         red_in   = 8'd0;
         green_in = 8'd0;
         blue_in  = 8'd0;
      end else begin
         red_in   = r_sum[23:16];
         green_in = g_sum[23:16];
         blue_in  = b_sum[23:16];
      end
   end

   assign out_ready    = !out_valid_ff || !rsp_stall;
   assign dv_rdy[NDIV] = out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_ready) begin
         out_valid_ff <= dv_vld[NDIV];
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready) begin
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;
   assign rsp_alpha = alpha_ff;

   // Transparent pixels come out all zero
   a_zero_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alpha == 8'd0 |->
         rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0)
      else $error("transparent pixel with nonzero color");

   // A taken result lets the whole chain advance
   a_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |-> !req_stall)
      else $error("request stalled while result taken");

   // Zero inner alpha never gives visible pixels
   a_inner_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && inner_ff[7:0] == 8'd0 |-> rsp_alpha == 8'd0)
      else $error("alpha above inner alpha");

endmodule

// File: test/radial_gradient_pixel_tb.sv
// Testbench for radial_gradient_pixel: drives pixel requests and register writes,
// predicts each RGBA result in a scoreboard class and checks results in order.
// Depends on rgp_pkg and the radial_gradient_pixel RTL.
`timescale 1ns / 1ps

module radial_gradient_pixel_tb;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } rgba_type;

   // Gradient predictor and queue of expected pixels.
   class gradient_scoreboard;
      logic [12:0] width_reg, height_reg;
      logic [15:0] density_reg;
      logic [31:0] inner_reg;
      logic [23:0] outer_reg;
      rgba_type    pending_pixels[$];
      int          errors;

      function new();
         errors = 0;
         reset_regs();
      endfunction

      function void reset_regs();
         width_reg = 13'd256;
         height_reg = 13'd256;
         density_reg = 16'd32768;
         inner_reg = 32'hFFFF_FFFF;
         outer_reg = 24'd0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            rgp_pkg::CSR_IMAGE_WIDTH: width_reg = data[12:0];
            rgp_pkg::CSR_IMAGE_HEIGHT: height_reg = data[12:0];
            rgp_pkg::CSR_DENSITY: density_reg = data[15:0];
            rgp_pkg::CSR_INNER_COLOR: inner_reg = data;
            rgp_pkg::CSR_OUTER_COLOR: outer_reg = data[23:0];
            default: ;
         endcase
      endfunction

      function automatic longint unsigned int_sqrt(longint unsigned v);
         longint unsigned root, bitv;
         root = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= root + bitv) begin
               v -= root + bitv;
               root = (root >> 1) + bitv;
            end else begin
               root >>= 1;
            end
            bitv >>= 2;
         end
         return root;
      endfunction

      function automatic logic [7:0] mix(longint unsigned o, longint unsigned i,
                                         longint unsigned f);
         longint unsigned s;
         s = (o * f + i * (65536 - f)) >> 16;
         return s[7:0];
      endfunction

      // Note one accepted request: compute the expected pixel.
      function void note_pixel(logic [11:0] px, logic [11:0] py);
         longint w, h, m, dx, dy, root_dist, num, den, dens;
         longint unsigned f, a;
         rgba_type p;
         w = (width_reg > 4096) ? 4096 : width_reg;
         h = (height_reg > 4096) ? 4096 : height_reg;
         m = (w < h) ? w : h;
         dx = 2 * longint'(px) - w;
         dy = 2 * longint'(py) - h;
         dens = density_reg;
         root_dist = int_sqrt(longint'(dx * dx + dy * dy) << 16);
         num = root_dist * 256 - m * dens;
         den = m * (65536 - dens);
         if (num <= 0) f = 0;
         else if (num >= den) f = 65536;
         else f = (num * 65536) / den;
         a = ((inner_reg[7:0] * (65536 - f)) >> 16) & 8'hFF;
         p = '0;
         if (a != 0) begin
            p.red = mix(outer_reg[23:16], inner_reg[31:24], f);
            p.green = mix(outer_reg[15:8], inner_reg[23:16], f);
            p.blue = mix(outer_reg[7:0], inner_reg[15:8], f);
            p.alpha = a[7:0];
         end
         pending_pixels.push_back(p);
      endfunction

      // Check one accepted result against the oldest expectation.
      function void check_pixel(rgba_type got);
         rgba_type exp_p;
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         exp_p = pending_pixels.pop_front();
         if (got.red !== exp_p.red)
            $display("%0t: red expected %h actual %h", $time, exp_p.red, got.red);
         if (got.green !== exp_p.green)
            $display("%0t: green expected %h actual %h", $time, exp_p.green, got.green);
         if (got.blue !== exp_p.blue)
            $display("%0t: blue expected %h actual %h", $time, exp_p.blue, got.blue);
         if (got.alpha !== exp_p.alpha)
            $display("%0t: alpha expected %h actual %h", $time, exp_p.alpha, got.alpha);
         if (got !== exp_p) errors++;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [11:0] req_pixel_x = 0;
   logic [11:0] req_pixel_y = 0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [7:0]  rsp_red, rsp_green, rsp_blue, rsp_alpha;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = 0;
   logic [31:0] csr_data = 0;

   gradient_scoreboard sb = new();
   bit   hold_rsp = 0;
   bit   long_hold = 0;
   int   cycle_count = 0;

   radial_gradient_pixel u_top (.*);

   always #6 clock = ~clock;

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_pixel({rsp_red, rsp_green, rsp_blue, rsp_alpha});
   end

   // Receiver: random stalls per result, plus one long hold-off on request.
   initial begin : receiver
      int gap;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            long_hold = 0;
         end
         gap = hold_rsp ? 0 : $urandom_range(0, 17);
         if ($urandom_range(0, 3) == 0) gap = 0;
         if (gap > 0) begin
            rsp_stall <= 1;
            repeat (gap - 1) @(posedge clock);
            @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   task automatic send_pixel(logic [11:0] px, logic [11:0] py, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do @(posedge clock); while (req_stall);
      sb.note_pixel(px, py);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      csr_valid <= 0;
   endtask

   // Idle pause: wait for every pending result.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (sb.pending_pixels.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_regs(logic [12:0] w, logic [12:0] h, logic [15:0] d,
                           logic [31:0] ic, logic [23:0] oc);
      write_csr(rgp_pkg::CSR_IMAGE_WIDTH, {$urandom} & 32'hFFFF_E000 | 32'(w));
      write_csr(rgp_pkg::CSR_IMAGE_HEIGHT, 32'(h));
      write_csr(rgp_pkg::CSR_DENSITY, 32'(d));
      write_csr(rgp_pkg::CSR_INNER_COLOR, ic);
      write_csr(rgp_pkg::CSR_OUTER_COLOR, {$urandom} & 32'hFF00_0000 | 32'(oc));
   endtask

   task automatic random_pixels(int count, logic [12:0] w, logic [12:0] h);
      logic [11:0] px, py;
      for (int i = 0; i < count; i++) begin
         // mostly inside the image, sometimes anywhere
         if ($urandom_range(0, 4) == 0 || w == 0 || h == 0) begin
            px = 12'($urandom); py = 12'($urandom);
         end else begin
            px = 12'($urandom_range(0, (w > 4096 ? 4096 : w) - 1));
            py = 12'($urandom_range(0, (h > 4096 ? 4096 : h) - 1));
         end
         send_pixel(px, py, $urandom_range(0, 4) == 0 || (i % 40) < 8);
      end
   endtask

   initial begin : stimulus
      logic [12:0] w, h;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: default registers, centre, corners, extreme coordinates.
      send_pixel(12'd128, 12'd128, 1);
      send_pixel(12'd0, 12'd0, 1);
      send_pixel(12'd255, 12'd255, 0);
      send_pixel(12'hFFF, 12'hFFF, 0);
      send_pixel(12'hFFF, 12'd0, 0);
      send_pixel(12'd0, 12'hFFF, 0);
      send_pixel(12'd160, 12'd128, 0);
      send_pixel(12'd200, 12'd128, 0);
      drain();

      // Zero image size: only the exact centre is inner.
      set_regs(13'd0, 13'd0, 16'd0, 32'h1234_56FF, 24'hABCDEF);
      send_pixel(12'd0, 12'd0, 1);
      send_pixel(12'd1, 12'd0, 1);
      send_pixel(12'hAAA, 12'h555, 0);
      drain();

      // Oversized dimensions saturate; density at its top.
      set_regs(13'h1FFF, 13'd5000, 16'hFFFF, 32'h8040_2001, 24'hFFFFFF);
      send_pixel(12'd2048, 12'd2048, 1);
      send_pixel(12'd2100, 12'd2048, 1);
      send_pixel(12'h555, 12'hAAA, 1);
      drain();

      // Odd sizes, zero alpha, one-pixel image.
      set_regs(13'd1, 13'd1, 16'd0, 32'hFFFF_FF00, 24'h010203);
      send_pixel(12'd0, 12'd0, 1);
      send_pixel(12'd1, 12'd1, 1);
      drain();
      write_csr(3'd7, 32'hFFFF_FFFF);
      write_csr(3'd5, 32'd0);

      // Long receiver hold-off while requests keep coming.
      set_regs(13'd64, 13'd48, 16'd16384, 32'hF0E0_D0C0, 24'h102030);
      long_hold = 1;
      random_pixels(80, 13'd64, 13'd48);
      drain();

      // Random phases with random settings.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin w = 13'($urandom_range(1, 16)); h = 13'($urandom_range(1, 16)); end
            1: begin w = 13'($urandom_range(1, 300)); h = 13'($urandom_range(1, 300)); end
            2: begin w = 13'($urandom_range(0, 8191)); h = 13'($urandom_range(0, 8191)); end
            default: begin w = 13'd4096; h = 13'($urandom_range(1, 4096)); end
         endcase
         set_regs(w, h, 16'($urandom), $urandom, 24'($urandom));
         random_pixels(40, w, h);
         drain();
      end

      if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/rgp_pkg.sv
rtl/rgp_sqrt_cell.sv
rtl/rgp_div_cell.sv
rtl/radial_gradient_pixel.sv
test/radial_gradient_pixel_tb.sv
